// ===== rtl/spc_pkg.sv =====
// shared types, widths and saturation helper for the sphere pair contact core
// no dependencies
`default_nettype none
package spc_pkg;

  localparam int unsigned CW     = 32;
  localparam int unsigned RW     = 31;
  localparam int unsigned SQ_W   = 66;
  localparam int unsigned LEN_W  = 33;
  localparam int unsigned REM_W  = 67;
  localparam int unsigned PROD_W = 63;
  localparam int unsigned DIV_W  = 64;
  localparam int unsigned NLANE  = 6;

  typedef logic [2:0][CW-1:0] vec_t;

  typedef struct packed {
    logic          present;
    vec_t          p0;
    vec_t          p1;
    logic [2:0]    neg;
    vec_t          mag;
    logic [RW-1:0] r0;
    logic [RW-1:0] r1;
  } side_t;

  typedef struct packed {
    logic       contact;
    logic       zero;
    vec_t       p0;
    vec_t       p1;
    logic [2:0] neg;
  } post_t;

  function automatic logic [CW-1:0] sat32(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] hi;
    logic signed [CW+1:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[CW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/spc_isqrt.sv =====
// pipelined integer square root, one result bit per stage, carries side data
// depends on spc_pkg
`default_nettype none
module spc_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [spc_pkg::SQ_W-1:0]   in_sq,
  input  wire spc_pkg::side_t             in_side,
  output logic                            out_valid,
  output logic [spc_pkg::LEN_W-1:0]       out_len,
  output spc_pkg::side_t                  out_side
);

  localparam int unsigned NST = spc_pkg::LEN_W;

  logic                         v_a    [0:NST];
  logic [spc_pkg::LEN_W-1:0]    res_a  [0:NST];
  logic [spc_pkg::REM_W-1:0]    rem_a  [0:NST];
  spc_pkg::side_t               side_a [0:NST];

  assign v_a[0]    = in_valid;
  assign res_a[0]  = '0;
  assign rem_a[0]  = {1'b0, in_sq};
  assign side_a[0] = in_side;

  for (genvar i = 0; i < NST; i++) begin : g_st
    localparam int unsigned B = NST - 1 - i;
    logic [spc_pkg::REM_W-1:0] trial;
    logic                      take;

    assign trial = ({{(spc_pkg::REM_W-spc_pkg::LEN_W){1'b0}}, res_a[i]} << (B + 1))
                 | ({{(spc_pkg::REM_W-1){1'b0}}, 1'b1} << (2 * B));
    assign take  = rem_a[i] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_a[i+1] <= 1'b0;
      end else if (en) begin
        v_a[i+1] <= v_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_a[i+1] <= side_a[i];
        if (take) begin
          rem_a[i+1] <= rem_a[i] - trial;
          res_a[i+1] <= res_a[i] | ({{(spc_pkg::LEN_W-1){1'b0}}, 1'b1} << B);
        end else begin
          rem_a[i+1] <= rem_a[i];
          res_a[i+1] <= res_a[i];
        end
      end
    end
  end

  assign out_valid = v_a[NST];
  assign out_len   = res_a[NST];
  assign out_side  = side_a[NST];

endmodule
`default_nettype wire

// ===== rtl/spc_div.sv =====
// pipelined restoring divider, six lanes sharing one divisor, one quotient bit per stage
// depends on spc_pkg
`default_nettype none
module spc_div (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        en,
  input  wire logic                                        in_valid,
  input  wire logic [spc_pkg::LEN_W-1:0]                   in_len,
  input  wire logic [spc_pkg::NLANE-1:0][spc_pkg::PROD_W-1:0] in_prod,
  input  wire spc_pkg::post_t                              in_post,
  output logic                                             out_valid,
  output logic [spc_pkg::NLANE-1:0][spc_pkg::RW-1:0]       out_quo,
  output spc_pkg::post_t                                   out_post
);

  localparam int unsigned NST = spc_pkg::RW;

  typedef logic [spc_pkg::NLANE-1:0][spc_pkg::PROD_W-1:0] rem_vec_t;
  typedef logic [spc_pkg::NLANE-1:0][spc_pkg::RW-1:0]     quo_vec_t;

  logic                      v_a    [0:NST];
  logic [spc_pkg::LEN_W-1:0] len_a  [0:NST];
  rem_vec_t                  rem_a  [0:NST];
  quo_vec_t                  quo_a  [0:NST];
  spc_pkg::post_t            post_a [0:NST];

  assign v_a[0]    = in_valid;
  assign len_a[0]  = in_len;
  assign rem_a[0]  = in_prod;
  assign quo_a[0]  = '0;
  assign post_a[0] = in_post;

  for (genvar i = 0; i < NST; i++) begin : g_st
    localparam int unsigned K = NST - 1 - i;
    logic [spc_pkg::DIV_W-1:0] dshift;
    rem_vec_t                  rem_nxt;
    quo_vec_t                  quo_nxt;

    assign dshift = {{(spc_pkg::DIV_W-spc_pkg::LEN_W){1'b0}}, len_a[i]} << K;

    always_comb begin
      for (int l = 0; l < spc_pkg::NLANE; l++) begin
        if ({1'b0, rem_a[i][l]} >= dshift) begin
          rem_nxt[l] = rem_a[i][l] - dshift[spc_pkg::PROD_W-1:0];
          quo_nxt[l] = quo_a[i][l] | ({{(spc_pkg::RW-1){1'b0}}, 1'b1} << K);
        end else begin
          rem_nxt[l] = rem_a[i][l];
          quo_nxt[l] = quo_a[i][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_a[i+1] <= 1'b0;
      end else if (en) begin
        v_a[i+1] <= v_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_a[i+1]  <= len_a[i];
        rem_a[i+1]  <= rem_nxt;
        quo_a[i+1]  <= quo_nxt;
        post_a[i+1] <= post_a[i];
      end
    end
  end

  assign out_valid = v_a[NST];
  assign out_quo   = quo_a[NST];
  assign out_post  = post_a[NST];

endmodule
`default_nettype wire

// ===== rtl/sphere_pair_contact_core.sv =====
// sphere pair contact core top level: difference, squares, root, scale and saturation stages
// depends on spc_pkg, spc_isqrt and spc_div
`default_nettype none
// Takes one sphere pair per cycle while no stall holds the pipeline and returns
// one result per pair, in order, through these stages to the output register
// (4 front stages, 33 square root stages, one test and multiply stage,
// 31 divider stages, two stages to form and saturate the points and gap).
// The whole pipeline advances while the output register is empty or being
// taken; a stall at the output holds every stage. When there is no contact
// the points and gap read as zero.
module sphere_pair_contact_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // first_radius, second_radius, two zero bits
  input  wire logic [255:0] in_tdata,
  // bodies_present
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z,
  // gap_x, gap_y, gap_z
  output logic [287:0]      out_tdata,
  // contact
  output logic [0:0]        out_tuser
);

  localparam int unsigned CW = spc_pkg::CW;
  localparam int unsigned RW = spc_pkg::RW;

  logic en;

  // stage 1: input register
  logic           s1_v_r;
  logic           s1_pres_r;
  spc_pkg::vec_t  s1_p0_r;
  spc_pkg::vec_t  s1_p1_r;
  logic [RW-1:0]  s1_r0_r;
  logic [RW-1:0]  s1_r1_r;

  // stage 2: difference
  logic           s2_v_r;
  spc_pkg::side_t s2_side_r;
  spc_pkg::side_t s2_side_nxt;

  // stage 3: squares
  logic           s3_v_r;
  spc_pkg::side_t s3_side_r;
  logic [2:0][2*CW-1:0] s3_sq_r;

  // stage 4: sum of squares
  logic           s4_v_r;
  spc_pkg::side_t s4_side_r;
  logic [spc_pkg::SQ_W-1:0] s4_sum_r;

  logic                        rt_v;
  logic [spc_pkg::LEN_W-1:0]   rt_len;
  spc_pkg::side_t              rt_side;

  // stage 5: contact test and products
  logic           s5_v_r;
  logic [spc_pkg::LEN_W-1:0] s5_len_r;
  logic [spc_pkg::NLANE-1:0][spc_pkg::PROD_W-1:0] s5_prod_r;
  spc_pkg::post_t s5_post_r;
  spc_pkg::post_t s5_post_nxt;
  logic [spc_pkg::LEN_W:0] len_ext;
  logic [spc_pkg::LEN_W:0] r0_ext;
  logic [spc_pkg::LEN_W:0] r1_ext;

  logic                                    dv_v;
  logic [spc_pkg::NLANE-1:0][RW-1:0]       dv_quo;
  spc_pkg::post_t                          dv_post;

  // stage 6: points
  logic           s6_v_r;
  logic           s6_contact_r;
  spc_pkg::vec_t  s6_pa_r;
  spc_pkg::vec_t  s6_pb_r;
  spc_pkg::vec_t  pa_nxt;
  spc_pkg::vec_t  pb_nxt;

  // stage 7: output register
  logic           out_v_r;
  logic           out_contact_r;
  spc_pkg::vec_t  out_pa_r;
  spc_pkg::vec_t  out_pb_r;
  spc_pkg::vec_t  out_gap_r;
  spc_pkg::vec_t  gap_nxt;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_tvalid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= rt_v;
      s6_v_r  <= dv_v;
      out_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pres_r <= in_tuser[0];
      s1_p0_r   <= in_tdata[3*CW-1:0];
      s1_p1_r   <= in_tdata[6*CW-1:3*CW];
      s1_r0_r   <= in_tdata[6*CW+RW-1:6*CW];
      s1_r1_r   <= in_tdata[6*CW+2*RW-1:6*CW+RW];
    end
  end

  always_comb begin
    logic signed [CW:0] d;
    s2_side_nxt.present = s1_pres_r;
    s2_side_nxt.p0      = s1_p0_r;
    s2_side_nxt.p1      = s1_p1_r;
    s2_side_nxt.r0      = s1_r0_r;
    s2_side_nxt.r1      = s1_r1_r;
    for (int a = 0; a < 3; a++) begin
      d = $signed({s1_p1_r[a][CW-1], s1_p1_r[a]}) - $signed({s1_p0_r[a][CW-1], s1_p0_r[a]});
      s2_side_nxt.neg[a] = d[CW];
      if (d[CW]) begin
        s2_side_nxt.mag[a] = 32'(-d);
      end else begin
        s2_side_nxt.mag[a] = d[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r <= s2_side_nxt;
      s3_side_r <= s2_side_r;
      for (int a = 0; a < 3; a++) begin
        s3_sq_r[a] <= s2_side_r.mag[a] * s2_side_r.mag[a];
      end
      s4_side_r <= s3_side_r;
      s4_sum_r  <= {2'b00, s3_sq_r[0]} + {2'b00, s3_sq_r[1]} + {2'b00, s3_sq_r[2]};
    end
  end

  spc_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_sq     (s4_sum_r),
    .in_side   (s4_side_r),
    .out_valid (rt_v),
    .out_len   (rt_len),
    .out_side  (rt_side)
  );

  assign len_ext = {1'b0, rt_len};
  assign r0_ext  = {3'b000, rt_side.r0};
  assign r1_ext  = {3'b000, rt_side.r1};

  always_comb begin
    s5_post_nxt.zero    = (rt_len == '0);
    s5_post_nxt.contact = rt_side.present
                        && (s5_post_nxt.zero
                            || ((len_ext + r1_ext >= r0_ext) && (len_ext <= r0_ext + r1_ext)));
    s5_post_nxt.p0      = rt_side.p0;
    s5_post_nxt.p1      = rt_side.p1;
    s5_post_nxt.neg     = rt_side.neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_len_r  <= rt_len;
      s5_post_r <= s5_post_nxt;
      for (int a = 0; a < 3; a++) begin
        s5_prod_r[a]   <= rt_side.mag[a] * rt_side.r0;
        s5_prod_r[a+3] <= rt_side.mag[a] * rt_side.r1;
      end
    end
  end

  spc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_v_r),
    .in_len    (s5_len_r),
    .in_prod   (s5_prod_r),
    .in_post   (s5_post_r),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_post  (dv_post)
  );

  always_comb begin
    logic signed [CW+1:0] oa;
    logic signed [CW+1:0] ob;
    for (int a = 0; a < 3; a++) begin
      oa = $signed({3'b000, dv_quo[a]});
      ob = $signed({3'b000, dv_quo[a+3]});
      if (dv_post.zero) begin
        oa = '0;
        ob = '0;
      end else if (dv_post.neg[a]) begin
        oa = -oa;
        ob = -ob;
      end
      pa_nxt[a] = spc_pkg::sat32($signed({{2{dv_post.p0[a][CW-1]}}, dv_post.p0[a]}) + oa);
      pb_nxt[a] = spc_pkg::sat32($signed({{2{dv_post.p1[a][CW-1]}}, dv_post.p1[a]}) - ob);
      if (!dv_post.contact) begin
        pa_nxt[a] = '0;
        pb_nxt[a] = '0;
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      gap_nxt[a] = spc_pkg::sat32($signed({{2{s6_pb_r[a][CW-1]}}, s6_pb_r[a]})
                                - $signed({{2{s6_pa_r[a][CW-1]}}, s6_pa_r[a]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_contact_r  <= dv_post.contact;
      s6_pa_r       <= pa_nxt;
      s6_pb_r       <= pb_nxt;
      out_contact_r <= s6_contact_r;
      out_pa_r      <= s6_pa_r;
      out_pb_r      <= s6_pb_r;
      out_gap_r     <= gap_nxt;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tuser[0] = out_contact_r;
  assign out_tdata    = {out_gap_r, out_pb_r, out_pa_r};

endmodule
`default_nettype wire

// ===== tb/tb_sphere_pair_contact_core.sv =====
// testbench for sphere_pair_contact_core: random and directed sphere pairs, results
// checked in order against a bit-exact contact predictor; depends on spc_pkg and the rtl
`default_nettype none
module tb_sphere_pair_contact_core;

  typedef struct packed {
    logic                present;
    logic signed [31:0]  ax, ay, az, bx, by, bz;
    logic [30:0]         r0, r1;
  } pair_t;

  typedef struct packed {
    logic         contact;
    logic [287:0] data;
  } contact_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;
  logic [0:0]   out_tuser;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       stim_done = 1'b0;
  bit       hold_sender = 1'b0;
  int       send_wait = 0;
  int       take_wait = 0;

  sphere_pair_contact_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] clamp32(input logic signed [67:0] v);
    if (v > 68'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -68'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic contact_t predict_contact(input pair_t p);
    contact_t           c;
    logic signed [67:0] a[3], b[3], d[3], oa, ob;
    logic [67:0]        mag, q;
    logic [131:0]       sum, cand;
    logic [67:0]        len;
    logic [31:0]        pa[3], pb[3], gp[3];
    bit                 hit;
    c = '0;
    if (!p.present) return c;
    a[0] = $signed(p.ax); a[1] = $signed(p.ay); a[2] = $signed(p.az);
    b[0] = $signed(p.bx); b[1] = $signed(p.by); b[2] = $signed(p.bz);
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = b[i] - a[i];
      mag = d[i] < 0 ? -d[i] : d[i];
      sum += mag * mag;
    end
    len = '0;
    for (int k = 32; k >= 0; k--) begin
      cand = len | (68'd1 << k);
      if (cand * cand <= sum) len = cand;
    end
    hit = (sum == 0) || ((len + p.r1 >= p.r0) && (len <= 68'(p.r0) + p.r1));
    if (!hit) return c;
    c.contact = 1'b1;
    for (int i = 0; i < 3; i++) begin
      oa = 0; ob = 0;
      if (len != 0) begin
        mag = d[i] < 0 ? -d[i] : d[i];
        q = (mag * p.r0) / len; oa = d[i] < 0 ? -$signed(q) : $signed(q);
        q = (mag * p.r1) / len; ob = d[i] < 0 ? -$signed(q) : $signed(q);
      end
      pa[i] = clamp32(a[i] + oa);
      pb[i] = clamp32(b[i] - ob);
      gp[i] = clamp32(68'($signed(pb[i])) - 68'($signed(pa[i])));
    end
    c.data = {gp[2], gp[1], gp[0], pb[2], pb[1], pb[0], pa[2], pa[1], pa[0]};
    return c;
  endfunction

  function automatic logic [31:0] rand_coord(input int sel);
    case (sel)
      0: return $urandom();
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    sel;
    logic [67:0] span;
    sel = $urandom_range(0, 9);
    p.present = ($urandom_range(0, 9) != 0);
    p.ax = rand_coord(sel < 2 ? sel : 3 + sel % 3);
    p.ay = rand_coord(sel < 2 ? sel : 3);
    p.az = rand_coord(sel < 2 ? $urandom_range(0, 3) : 3);
    p.bx = p.ax + 32'($signed($urandom_range(0, 200000)) - 100000);
    p.by = p.ay + 32'($signed($urandom_range(0, 200000)) - 100000);
    p.bz = p.az + 32'($signed($urandom_range(0, 200000)) - 100000);
    if (sel == 9) begin
      p.bx = $urandom(); p.by = $urandom(); p.bz = $urandom();
    end
    span = 68'($urandom_range(0, 180000));
    p.r0 = $urandom_range(0, 1) ? 31'($urandom_range(0, 200000)) : 31'(span);
    p.r1 = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 200000));
    if (sel == 8) begin
      p.r0 = $urandom(); p.r1 = $urandom();
    end
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_contacts.push_back(predict_contact(pending_pairs.pop_front()));
        send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (send_wait > 0) send_wait--;
      if (pending_pairs.size() != 0 && send_wait == 0 && !hold_sender) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, pending_pairs[0].r1, pending_pairs[0].r0,
                      pending_pairs[0].bz, pending_pairs[0].by, pending_pairs[0].bx,
                      pending_pairs[0].az, pending_pairs[0].ay, pending_pairs[0].ax};
        in_tuser  <= pending_pairs[0].present;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    contact_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_contacts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %h %h", out_tuser, out_tdata);
        end else begin
          want = expected_contacts.pop_front();
          if (want.contact !== out_tuser[0] || want.data !== out_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %b %h got %b %h", want.contact, want.data,
                       out_tuser, out_tdata);
          end
        end
        take_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (take_wait > 0) take_wait--;
      out_tready <= (take_wait == 0);
    end
  end

  initial begin
    pair_t p;
    p = '0; p.present = 1'b1;
    pending_pairs.push_back(p);
    p.r0 = 31'h7FFF_FFFF; p.r1 = 31'h7FFF_FFFF;
    p.ax = 32'h8000_0000; p.ay = 32'h8000_0000; p.az = 32'h8000_0000;
    p.bx = 32'h7FFF_FFFF; p.by = 32'h7FFF_FFFF; p.bz = 32'h7FFF_FFFF;
    pending_pairs.push_back(p);
    p.ax = 32'h7FFF_FFFF; p.bx = 32'h8000_0000; p.ay = 0; p.by = 0; p.az = 0; p.bz = 0;
    pending_pairs.push_back(p);
    p.present = 1'b0;
    pending_pairs.push_back(p);
    p = '0; p.present = 1'b1; p.bx = 32'h0003_0000; p.r0 = 31'h0002_0000; p.r1 = 31'h0001_0000;
    pending_pairs.push_back(p);
    p.r1 = 31'h0000_FFFF;
    pending_pairs.push_back(p);
    p.r0 = 31'h0005_0000; p.r1 = 31'h0002_0000;
    pending_pairs.push_back(p);
    p.r1 = 31'h0001_FFFF;
    pending_pairs.push_back(p);
    p.ax = 32'h1234_5678; p.ay = 32'hFEDC_BA98; p.az = 32'h0F0F_0F0F;
    p.bx = p.ax; p.by = p.ay; p.bz = p.az; p.r0 = 31'h5555_5555; p.r1 = 31'h2AAA_AAAA;
    pending_pairs.push_back(p);
    p.bx = 32'hFFFF_FFFF; p.by = 32'hAAAA_AAAA; p.bz = 32'h5555_5555; p.r0 = 0; p.r1 = 0;
    pending_pairs.push_back(p);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_pairs.size() == 0);
    @(posedge clk);
    hold_sender = 1'b1;
    wait (expected_contacts.size() == 0);
    hold_sender = 1'b0;
    for (int n = 0; n < 1100; n++) pending_pairs.push_back(rand_pair());
    wait (pending_pairs.size() == 0 && !in_tvalid);
    wait (expected_contacts.size() == 0);
    repeat (100) @(posedge clk);
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (stim_done) begin
      if (mismatches == 0 && expected_contacts.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end else if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
`default_nettype wire
